>>> sv/ktbl_pkg.sv
package ktbl_pkg;

    localparam int KEY_W      = 8;
    localparam int TOKEN_W    = 16;
    localparam int TIME_W     = 48;
    localparam int FRAC_W     = 32;
    localparam int LEVEL_W    = TOKEN_W + FRAC_W;
    localparam int RATE_W     = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic                ENABLE_RESET   = 1'b0;
    localparam logic [TOKEN_W-1:0]  CAPACITY_RESET = 16'd100;
    localparam logic [RATE_W-1:0]   RATE_RESET     = 32'd42950;

    // Register index, taken from paddr word bits
    typedef enum logic [1:0] {
        REG_ENABLE   = 2'd0,
        REG_CAPACITY = 2'd1,
        REG_RATE     = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic                enabled;
        logic [TOKEN_W-1:0]  capacity;
        logic [RATE_W-1:0]   rate;
    } cfg_t;

    // One bucket entry: 16.32 token level and time of last refill
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  stamp;
    } entry_t;

    typedef struct packed {
        logic   hit;
        entry_t entry;
    } mem_rd_t;

    typedef struct packed {
        logic   en;
        entry_t entry;
    } mem_wr_t;

endpackage

>>> sv/ktbl_if.sv
interface ktbl_req_if import ktbl_pkg::*;;
    logic               valid;
    logic               ready;
    logic [KEY_W-1:0]   key_slot;
    logic [TOKEN_W-1:0] tokens_requested;
    logic [TIME_W-1:0]  timestamp;

    modport source (output valid, output key_slot, output tokens_requested,
                    output timestamp, input ready);
    modport sink (input valid, input key_slot, input tokens_requested,
                  input timestamp, output ready);
endinterface

interface ktbl_rsp_if import ktbl_pkg::*;;
    logic               valid;
    logic               ready;
    logic               granted;
    logic [TOKEN_W-1:0] tokens_left;
    logic               fresh_bucket;

    modport source (output valid, output granted, output tokens_left,
                    output fresh_bucket, input ready);
    modport sink (input valid, input granted, input tokens_left,
                  input fresh_bucket, output ready);
endinterface

>>> sv/ktbl_cfg.sv
module ktbl_cfg import ktbl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_hit;
    logic [1:0] word_idx;

    assign pready   = 1'b1;
    assign wr_hit   = psel && penable && pwrite;
    assign word_idx = paddr[3:2];
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_hit)
        begin
            case (word_idx)
                REG_ENABLE:   cfg_next.enabled  = pwdata[0];
                REG_CAPACITY: cfg_next.capacity = pwdata[TOKEN_W-1:0];
                REG_RATE:     cfg_next.rate     = pwdata[RATE_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (word_idx)
            REG_ENABLE:   prdata = {{(APB_DATA_W-1){1'b0}}, cfg_reg.enabled};
            REG_CAPACITY: prdata = {{(APB_DATA_W-TOKEN_W){1'b0}}, cfg_reg.capacity};
            REG_RATE:     prdata = cfg_reg.rate;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled  <= ENABLE_RESET;
            cfg_reg.capacity <= CAPACITY_RESET;
            cfg_reg.rate     <= RATE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> sv/ktbl_mem.sv
module ktbl_mem import ktbl_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int IDX_W = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output mem_rd_t          rd,
    input  logic [IDX_W-1:0] wr_idx,
    input  mem_wr_t          wr
);

    entry_t     mem [DEPTH];
    entry_t     rd_data_reg;
    logic       rd_hit_reg;
    logic [DEPTH-1:0] valid_reg;

    assign rd.hit   = rd_hit_reg;
    assign rd.entry = rd_data_reg;

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_idx] <= wr.entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    // Per-entry valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_idx];
            end
        end
    end

endmodule

>>> sv/keyed_token_bucket_limiter.sv
// Per-key token-bucket rate limiter. Each request item names a key slot
// (reduced modulo NUM_KEYS), a whole-token count and a 48-bit timestamp in
// ticks, and returns one result item: granted, whole tokens left in the
// bucket, and whether this request created the bucket. Buckets hold a 16.32
// fixed-point level and the time of the last refill in a one-port-read,
// one-port-write synchronous table of min(NUM_KEYS, 256) entries plus a valid
// bit per entry that reset clears at once, so no clearing pass is needed and
// the block takes items right after reset. A slot seen for the first time
// starts full. Refill is elapsed ticks times refill_per_tick, computed exactly
// and clamped to bucket_capacity once ticks have elapsed. While limiter_enabled
// is 0 every request is granted with tokens_left 0 and the table is untouched.
// Each item passes through accept and table read, elapsed time, split 48x32
// refill multiply, refill sum and clamp, grant decision with write-back (held
// until the result side is free); the read-modify-write of the table makes
// the block handle one item at a time. The next item is accepted while the
// previous result still sits in the output register. Configuration registers
// sit on the APB port at byte addresses 0 (limiter_enabled), 4
// (bucket_capacity) and 8 (refill_per_tick); write them only while idle.
module keyed_token_bucket_limiter import ktbl_pkg::*;
#(
    parameter int NUM_KEYS = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    ktbl_req_if.sink              req,
    ktbl_rsp_if.source            rsp
);

    // Slots beyond 255 are never addressed by an 8-bit key
    localparam int DEPTH = (NUM_KEYS < 256) ? NUM_KEYS : 256;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = TIME_W + RATE_W + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_MUL  = 5'b00100,
        S_SUM  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    cfg_t    cfg;
    mem_rd_t mem_rd;
    mem_wr_t mem_wr;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [TOKEN_W-1:0] want_reg, want_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [TIME_W-1:0]  elapsed_reg, elapsed_next;
    logic               fresh_reg, fresh_next;
    logic               hold_reg, hold_next;
    logic [63:0]        prod_lo_reg, prod_lo_next;
    logic [47:0]        prod_hi_reg, prod_hi_next;

    logic               rsp_valid_reg, rsp_valid_next;
    logic               granted_reg, granted_next;
    logic [TOKEN_W-1:0] left_reg, left_next;
    logic               fresh_out_reg, fresh_out_next;

    logic [KEY_W-1:0]   slot_red;
    logic [IDX_W-1:0]   slot_idx;
    logic               accept;
    logic               out_free;
    logic               load_out;
    logic [LEVEL_W-1:0] cap_fx;
    logic [LEVEL_W-1:0] want_fx;
    logic [TIME_W-1:0]  base_stamp;
    logic [63:0]        mul_lo;
    logic [47:0]        mul_hi;
    logic [SUM_W-1:0]   sum_full;
    logic               over_cap;
    logic               grant;
    logic [LEVEL_W-1:0] level_after;

    ktbl_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ktbl_mem #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_mem
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept),
        .rd_idx (slot_idx),
        .rd     (mem_rd),
        .wr_idx (idx_reg),
        .wr     (mem_wr)
    );

    // Reduce the key modulo NUM_KEYS: binary long-division remainder,
    // one conditional subtract per key bit
    always_comb
    begin
        slot_red = req.key_slot;
        for (int k = KEY_W - 1; k >= 0; k--)
        begin
            if ({24'b0, slot_red} >= 32'(NUM_KEYS << k))
            begin
                slot_red = slot_red - KEY_W'(NUM_KEYS << k);
            end
        end
    end

    assign slot_idx = slot_red[IDX_W-1:0];

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && (state_reg == S_IDLE);

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign load_out  = (state_reg == S_DONE) && out_free;

    assign cap_fx  = {cfg.capacity, {FRAC_W{1'b0}}};
    assign want_fx = {want_reg, {FRAC_W{1'b0}}};

    // A new slot starts full, stamped with the request time
    assign base_stamp = mem_rd.hit ? mem_rd.entry.stamp : now_reg;

    // Refill product split into a 32x32 and a 16x32 multiply
    assign mul_lo = elapsed_reg[31:0] * cfg.rate;
    assign mul_hi = elapsed_reg[47:32] * cfg.rate;

    // Level plus exact refill; clamp to capacity
    assign sum_full = SUM_W'(level_reg) + SUM_W'(prod_lo_reg)
                    + SUM_W'({prod_hi_reg, 32'b0});
    assign over_cap = (|sum_full[SUM_W-1:LEVEL_W]) || (sum_full[LEVEL_W-1:0] > cap_fx);

    // Grant decision on the refilled level
    assign grant       = (level_reg >= want_fx);
    assign level_after = grant ? (level_reg - want_fx) : level_reg;

    // Write back level and stamp only while enforcing
    assign mem_wr.en          = load_out && cfg.enabled;
    assign mem_wr.entry.level = level_after;
    assign mem_wr.entry.stamp = now_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        want_next      = want_reg;
        now_next       = now_reg;
        level_next     = level_reg;
        elapsed_next   = elapsed_reg;
        fresh_next     = fresh_reg;
        hold_next      = hold_reg;
        prod_lo_next   = prod_lo_reg;
        prod_hi_next   = prod_hi_reg;
        granted_next   = granted_reg;
        left_next      = left_reg;
        fresh_out_next = fresh_out_reg;
        rsp_valid_next = rsp_valid_reg;

        // Drop the result once taken
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                // Latch the item; table read issues at this edge
                if (req.valid)
                begin
                    idx_next   = slot_idx;
                    want_next  = req.tokens_requested;
                    now_next   = req.timestamp;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                level_next   = mem_rd.hit ? mem_rd.entry.level : cap_fx;
                fresh_next   = !mem_rd.hit;
                elapsed_next = now_reg - base_stamp;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                prod_lo_next = mul_lo;
                prod_hi_next = mul_hi;
                hold_next    = (elapsed_reg == '0);
                state_next   = S_SUM;
            end
            S_SUM:
            begin
                // No elapsed time: keep the level as is, even above capacity
                if (!hold_reg)
                begin
                    level_next = over_cap ? cap_fx : sum_full[LEVEL_W-1:0];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (cfg.enabled)
                    begin
                        granted_next   = grant;
                        left_next      = level_after[LEVEL_W-1:FRAC_W];
                        fresh_out_next = fresh_reg;
                    end
                    else
                    begin
                        granted_next   = 1'b1;
                        left_next      = '0;
                        fresh_out_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath and result payload, no reset
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        want_reg      <= want_next;
        now_reg       <= now_next;
        level_reg     <= level_next;
        elapsed_reg   <= elapsed_next;
        fresh_reg     <= fresh_next;
        hold_reg      <= hold_next;
        prod_lo_reg   <= prod_lo_next;
        prod_hi_reg   <= prod_hi_next;
        granted_reg   <= granted_next;
        left_reg      <= left_next;
        fresh_out_reg <= fresh_out_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.granted      = granted_reg;
    assign rsp.tokens_left  = left_reg;
    assign rsp.fresh_bucket = fresh_out_reg;

endmodule
